// ===== rtl/core/arq_pkg.sv =====
// arq_pkg: shared constants, types and helpers of the arq sender window controller
// no dependencies; imported by arq_ring, arq_cmp and arq_sender_window_controller
`timescale 1ns / 1ps

package arq_pkg;

    // ring of packet slots, power of two so the slot of a number is its low bits
    localparam int RING_SLOTS = 16;
    localparam int WINDOW_CAP = 16;
    localparam int SLOT_W     = $clog2(RING_SLOTS);

    localparam int SEQ_W      = 32;
    localparam int OSEQ_W     = 31;
    localparam int LEN_W      = 11;
    localparam int RETRY_W    = 3;
    localparam int ATT_W      = 4;
    localparam int WIN_W      = 5;
    localparam int ACT_W      = 2;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam int STEP_MAX   = (RING_SLOTS > WINDOW_CAP) ? RING_SLOTS : WINDOW_CAP;
    localparam int STEP_W     = $clog2(STEP_MAX + 1);

    localparam logic [WIN_W-1:0]   WINDOW_RESET  = WIN_W'(2);
    localparam logic [RETRY_W-1:0] RETRIES_RESET = RETRY_W'(4);

    typedef enum logic [ACT_W-1:0] {
        ACT_GEN     = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_TIMEOUT = 2'd2
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SENT      = 3'd0,
        KIND_RESENT    = 3'd1,
        KIND_ABANDONED = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_BUSY      = 3'd4,
        KIND_ACK_DONE  = 3'd5,
        KIND_IGNORED   = 3'd6,
        KIND_TIMEOUT   = 3'd7
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW  = 1'b0,
        REG_RETRIES = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GEN,
        S_ACK_LO,
        S_ACK_HI,
        S_ACK_END,
        S_CHK,
        S_ABN,
        S_SKIP,
        S_RESEND,
        S_FLUSH
    } state_t;

    // one ring slot as seen on the read port
    typedef struct packed {
        logic               used;
        logic [SEQ_W-1:0]   seq;
        logic [LEN_W-1:0]   len;
        logic [RETRY_W-1:0] retries;
    } slot_t;

    // write request to the ring, all at one slot index
    typedef struct packed {
        logic               load;
        logic               clear;
        logic               ret_we;
        logic [RETRY_W-1:0] ret_val;
        logic [SEQ_W-1:0]   seq;
        logic [LEN_W-1:0]   len;
    } ring_wr_t;

    // shared compare unit flags
    typedef struct packed {
        logic lt;
        logic eq;
        logic ge_lim;
    } cmp_t;

    function automatic logic [RETRY_W-1:0] sat_inc(input logic [RETRY_W-1:0] r);
        return (r == {RETRY_W{1'b1}}) ? r : RETRY_W'(r + 1'b1);
    endfunction

    // negative numbers report as zero
    function automatic logic [OSEQ_W-1:0] rep_seq(input logic [SEQ_W-1:0] v);
        return v[SEQ_W-1] ? {OSEQ_W{1'b0}} : v[OSEQ_W-1:0];
    endfunction

endpackage

// ===== rtl/core/arq_ring.sv =====
// arq_ring: slot storage of the sender ring, used bits plus sequence, length and retries
// depends on arq_pkg
`timescale 1ns / 1ps

module arq_ring (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [arq_pkg::SLOT_W-1:0] idx,
    input  arq_pkg::ring_wr_t          wr,
    output arq_pkg::slot_t             rd
);
    import arq_pkg::*;

    logic [RING_SLOTS-1:0] used_reg;
    logic [RING_SLOTS-1:0] used_next;
    logic [SEQ_W-1:0]      seq_reg   [RING_SLOTS];
    logic [LEN_W-1:0]      len_reg   [RING_SLOTS];
    logic [RETRY_W-1:0]    retry_reg [RING_SLOTS];

    always_comb
    begin
        used_next = used_reg;
        if (wr.load)
        begin
            used_next[idx] = 1'b1;
        end
        else if (wr.clear)
        begin
            used_next[idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    // contents are only read where the used bit is set
    always_ff @(posedge clk)
    begin
        if (wr.load)
        begin
            seq_reg[idx]   <= wr.seq;
            len_reg[idx]   <= wr.len;
            retry_reg[idx] <= '0;
        end
        else if (wr.ret_we)
        begin
            retry_reg[idx] <= wr.ret_val;
        end
    end

    always_comb
    begin
        rd.used    = used_reg[idx];
        rd.seq     = seq_reg[idx];
        rd.len     = len_reg[idx];
        rd.retries = retry_reg[idx];
    end

endmodule

// ===== rtl/core/arq_cmp.sv =====
// arq_cmp: shared signed compare unit for sequence numbers and window limit
// depends on arq_pkg
`timescale 1ns / 1ps

module arq_cmp (
    input  logic [arq_pkg::SEQ_W-1:0] a,
    input  logic [arq_pkg::SEQ_W-1:0] b,
    input  logic [arq_pkg::WIN_W-1:0] lim,
    output arq_pkg::cmp_t             res
);
    import arq_pkg::*;

    logic [SEQ_W:0] diff;

    // sign-extended difference cannot overflow
    assign diff = {a[SEQ_W-1], a} - {b[SEQ_W-1], b};

    always_comb
    begin
        res.lt     = diff[SEQ_W];
        res.eq     = (a == b);
        res.ge_lim = !diff[SEQ_W]
                     && (diff[SEQ_W-1:0] >= {{(SEQ_W-WIN_W){1'b0}}, lim});
    end

endmodule

// ===== rtl/core/arq_sender_window_controller.sv =====
// arq_sender_window_controller: top level, sequencer around the slot ring and compare unit
// depends on arq_pkg, arq_ring, arq_cmp
`timescale 1ns / 1ps

// usage
//   request: start with action, seq_number and packet_length; taken at an edge where
//   start is high and busy is low. busy stays high until the final result is out.
//   action generate sends a new packet, ack releases slots, timeout retries or abandons.
//   results: one or more per request, each on the result ports for one cycle with
//   result_strobe high; last marks the final one. results cannot be held off.
//   config: cfg_write with cfg_index (0 window_size, 1 retry limit) and cfg_data,
//   taken at once; write only while busy is low.
// timing
//   generate, stop-and-wait ack, ignored requests: a single result, which is the final one
//   go-back-n ack: every ring slot is checked against the base on the shared compare unit,
//   and each used slot at or above the base is then checked against the ack
//   timeout resend: one window position per cycle, results stream out
//   abandon at the base: free slots are skipped one per cycle, after a full lap base jumps to next
//   busy drops in the cycle the final result is shown
// reset
//   base, next number and counter go to zero, all slots free, window 2, retries 4

module arq_sender_window_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [arq_pkg::ACT_W-1:0]      action,
    input  logic signed [arq_pkg::SEQ_W-1:0] seq_number,
    input  logic [arq_pkg::LEN_W-1:0]      packet_length,
    input  logic                           cfg_write,
    input  logic [arq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arq_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           result_strobe,
    output logic [arq_pkg::KIND_W-1:0]     kind,
    output logic [arq_pkg::OSEQ_W-1:0]     out_seq,
    output logic [arq_pkg::LEN_W-1:0]      out_length,
    output logic [arq_pkg::ATT_W-1:0]      attempt,
    output logic [arq_pkg::OSEQ_W-1:0]     window_base,
    output logic                           last
);
    import arq_pkg::*;

    // sequencer and window state
    state_t               state_reg, state_next;
    logic [SEQ_W-1:0]     base_reg, base_next;
    logic [SEQ_W-1:0]     nts_reg, nts_next;
    logic [SEQ_W-1:0]     cnt_reg, cnt_next;
    logic [WIN_W-1:0]     win_reg, win_next;
    logic [RETRY_W-1:0]   maxr_reg, maxr_next;

    // request being worked on
    action_t              act_reg, act_next;
    logic [SEQ_W-1:0]     sq_reg, sq_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 gbn_reg, gbn_next;
    logic [WIN_W-1:0]     weff_reg, weff_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [SEQ_W-1:0]     s_reg, s_next;
    logic                 found_reg, found_next;

    // pending result, held until the next one or the flush so the last one can be marked
    logic                 pend_valid_reg, pend_valid_next;
    kind_t                pend_kind_reg, pend_kind_next;
    logic [SEQ_W-1:0]     pend_seq_reg, pend_seq_next;
    logic [LEN_W-1:0]     pend_len_reg, pend_len_next;
    logic [ATT_W-1:0]     pend_att_reg, pend_att_next;

    // result output register
    logic                 strobe_reg, strobe_next;
    kind_t                kind_reg, kind_next;
    logic [OSEQ_W-1:0]    oseq_reg, oseq_next;
    logic [LEN_W-1:0]     olen_reg, olen_next;
    logic [ATT_W-1:0]     att_reg, att_next;
    logic [OSEQ_W-1:0]    wb_reg, wb_next;
    logic                 last_reg, last_next;

    // ring and compare unit hookup
    logic [SLOT_W-1:0]    ring_idx;
    ring_wr_t             ring_wr;
    slot_t                slot;
    logic [SEQ_W-1:0]     cmp_a;
    logic [SEQ_W-1:0]     cmp_b;
    cmp_t                 cmp;

    logic                 emit;
    logic                 emit_last;
    logic [WIN_W-1:0]     w_eff;
    logic [RETRY_W-1:0]   r_inc;

    arq_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (ring_idx),
        .wr    (ring_wr),
        .rd    (slot)
    );

    arq_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .lim (weff_reg),
        .res (cmp)
    );

    // window of zero acts as one, above the cap acts as the cap
    always_comb
    begin
        if (win_reg == '0)
        begin
            w_eff = WIN_W'(1);
        end
        else if (win_reg > WIN_W'(WINDOW_CAP))
        begin
            w_eff = WIN_W'(WINDOW_CAP);
        end
        else
        begin
            w_eff = win_reg;
        end
    end

    assign r_inc = sat_inc(slot.retries);

    // configuration writes
    always_comb
    begin
        win_next  = win_reg;
        maxr_next = maxr_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WINDOW:  win_next  = cfg_data;
                REG_RETRIES: maxr_next = cfg_data[RETRY_W-1:0];
                default:     win_next  = win_reg;
            endcase
        end
    end

    // sequencer: next state, ring requests and compare operands
    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        nts_next        = nts_reg;
        cnt_next        = cnt_reg;
        act_next        = act_reg;
        sq_next         = sq_reg;
        len_next        = len_reg;
        gbn_next        = gbn_reg;
        weff_next       = weff_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        s_next          = s_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_seq_next   = pend_seq_reg;
        pend_len_next   = pend_len_reg;
        pend_att_next   = pend_att_reg;
        ring_idx        = idx_reg;
        ring_wr         = '0;
        cmp_a           = base_reg;
        cmp_b           = nts_reg;
        emit            = 1'b0;
        emit_last       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next        = action_t'(action);
                    sq_next         = seq_number;
                    s_next          = seq_number;
                    len_next        = packet_length;
                    weff_next       = w_eff;
                    gbn_next        = (w_eff > WIN_W'(1));
                    idx_next        = '0;
                    step_next       = '0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    unique case (action_t'(action))
                        ACT_GEN:     state_next = S_GEN;
                        ACT_ACK:     state_next = (w_eff > WIN_W'(1)) ? S_ACK_LO : S_CHK;
                        ACT_TIMEOUT: state_next = S_CHK;
                        default:
                        begin
                            pend_kind_next = KIND_IGNORED;
                            pend_seq_next  = seq_number;
                            pend_len_next  = '0;
                            pend_att_next  = '0;
                            state_next     = S_FLUSH;
                        end
                    endcase
                end
            end

            S_GEN:
            begin
                ring_idx      = cnt_reg[SLOT_W-1:0];
                cmp_a         = nts_reg;
                cmp_b         = base_reg;
                pend_seq_next = cnt_reg;
                pend_len_next = '0;
                pend_att_next = '0;
                if (cmp.ge_lim)
                begin
                    pend_kind_next = KIND_FULL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (slot.used)
                    begin
                        pend_kind_next = KIND_BUSY;
                    end
                    else
                    begin
                        ring_wr.load   = 1'b1;
                        ring_wr.seq    = cnt_reg;
                        ring_wr.len    = len_reg;
                        nts_next       = nts_reg + 1'b1;
                        pend_kind_next = KIND_SENT;
                        pend_len_next  = len_reg;
                        pend_att_next  = ATT_W'(1);
                    end
                end
                state_next = S_FLUSH;
            end

            // go-back-n ack, low bound: slot number at or above the base
            S_ACK_LO:
            begin
                ring_idx = idx_reg;
                cmp_a    = slot.seq;
                cmp_b    = base_reg;
                if (slot.used && !cmp.lt)
                begin
                    state_next = S_ACK_HI;
                end
                else if (idx_reg == SLOT_W'(RING_SLOTS - 1))
                begin
                    state_next = S_ACK_END;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // high bound: slot number at or below the ack
            S_ACK_HI:
            begin
                ring_idx = idx_reg;
                cmp_a    = sq_reg;
                cmp_b    = slot.seq;
                if (!cmp.lt)
                begin
                    ring_wr.clear = 1'b1;
                    found_next    = 1'b1;
                end
                if (idx_reg == SLOT_W'(RING_SLOTS - 1))
                begin
                    state_next = S_ACK_END;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_ACK_LO;
                end
            end

            S_ACK_END:
            begin
                pend_seq_next = sq_reg;
                pend_len_next = '0;
                pend_att_next = '0;
                if (found_reg)
                begin
                    base_next      = sq_reg + 1'b1;
                    pend_kind_next = KIND_ACK_DONE;
                end
                else
                begin
                    pend_kind_next = KIND_IGNORED;
                end
                state_next = S_FLUSH;
            end

            // slot of the given number: stop-and-wait ack or timeout
            S_CHK:
            begin
                ring_idx      = sq_reg[SLOT_W-1:0];
                cmp_a         = slot.seq;
                cmp_b         = sq_reg;
                pend_seq_next = sq_reg;
                pend_len_next = '0;
                pend_att_next = '0;
                state_next    = S_FLUSH;
                if (!(slot.used && cmp.eq))
                begin
                    pend_kind_next = KIND_IGNORED;
                end
                else if (act_reg == ACT_ACK)
                begin
                    ring_wr.clear  = 1'b1;
                    base_next      = sq_reg + 1'b1;
                    pend_kind_next = KIND_ACK_DONE;
                end
                else
                begin
                    ring_wr.ret_we  = 1'b1;
                    ring_wr.ret_val = r_inc;
                    if (r_inc >= maxr_reg)
                    begin
                        ring_wr.clear  = 1'b1;
                        pend_kind_next = KIND_ABANDONED;
                        pend_len_next  = slot.len;
                        pend_att_next  = ATT_W'(r_inc);
                        if (gbn_reg)
                        begin
                            state_next = S_ABN;
                        end
                        else
                        begin
                            base_next = sq_reg + 1'b1;
                        end
                    end
                    else if (gbn_reg)
                    begin
                        state_next = S_RESEND;
                    end
                    else
                    begin
                        pend_kind_next = KIND_RESENT;
                        pend_len_next  = slot.len;
                        pend_att_next  = ATT_W'(r_inc) + 1'b1;
                    end
                end
            end

            // abandoned packet at the base moves the base on
            S_ABN:
            begin
                cmp_a = sq_reg;
                cmp_b = base_reg;
                if (cmp.eq)
                begin
                    base_next  = sq_reg + 1'b1;
                    step_next  = '0;
                    state_next = S_SKIP;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end

            // skip free slots up to next_to_send, a full lap jumps there
            S_SKIP:
            begin
                ring_idx = base_reg[SLOT_W-1:0];
                cmp_a    = base_reg;
                cmp_b    = nts_reg;
                if (step_reg == STEP_W'(RING_SLOTS))
                begin
                    if (cmp.lt)
                    begin
                        base_next = nts_reg;
                    end
                    state_next = S_FLUSH;
                end
                else if (cmp.lt && !slot.used)
                begin
                    base_next = base_reg + 1'b1;
                    step_next = step_reg + 1'b1;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end

            // go-back-n resend walk over the window from the timed-out number
            S_RESEND:
            begin
                ring_idx = s_reg[SLOT_W-1:0];
                cmp_a    = slot.seq;
                cmp_b    = s_reg;
                if (slot.used && cmp.eq)
                begin
                    ring_wr.ret_we  = 1'b1;
                    ring_wr.ret_val = r_inc;
                    emit            = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_kind_next  = KIND_RESENT;
                    pend_seq_next   = s_reg;
                    pend_len_next   = slot.len;
                    pend_att_next   = ATT_W'(r_inc) + 1'b1;
                end
                s_next    = s_reg + 1'b1;
                step_next = step_reg + 1'b1;
                if (STEP_W'(step_reg + 1'b1) == STEP_W'(weff_reg))
                begin
                    state_next = S_FLUSH;
                end
            end

            S_FLUSH:
            begin
                emit            = 1'b1;
                emit_last       = 1'b1;
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // results always come from the pending register; base is settled when it goes out
    always_comb
    begin
        strobe_next = emit;
        kind_next   = kind_reg;
        oseq_next   = oseq_reg;
        olen_next   = olen_reg;
        att_next    = att_reg;
        wb_next     = wb_reg;
        last_next   = last_reg;
        if (emit)
        begin
            kind_next = pend_kind_reg;
            oseq_next = rep_seq(pend_seq_reg);
            olen_next = pend_len_reg;
            att_next  = pend_att_reg;
            wb_next   = base_reg[OSEQ_W-1:0];
            last_next = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            base_reg       <= '0;
            nts_reg        <= '0;
            cnt_reg        <= '0;
            win_reg        <= WINDOW_RESET;
            maxr_reg       <= RETRIES_RESET;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            nts_reg        <= nts_next;
            cnt_reg        <= cnt_next;
            win_reg        <= win_next;
            maxr_reg       <= maxr_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        sq_reg        <= sq_next;
        len_reg       <= len_next;
        gbn_reg       <= gbn_next;
        weff_reg      <= weff_next;
        idx_reg       <= idx_next;
        step_reg      <= step_next;
        s_reg         <= s_next;
        found_reg     <= found_next;
        pend_kind_reg <= pend_kind_next;
        pend_seq_reg  <= pend_seq_next;
        pend_len_reg  <= pend_len_next;
        pend_att_reg  <= pend_att_next;
        kind_reg      <= kind_next;
        oseq_reg      <= oseq_next;
        olen_reg      <= olen_next;
        att_reg       <= att_next;
        wb_reg        <= wb_next;
        last_reg      <= last_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign out_seq       = oseq_reg;
    assign out_length    = olen_reg;
    assign attempt       = att_reg;
    assign window_base   = wb_reg;
    assign last          = last_reg;

    // final result of a request shows while the sequencer is already free
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |-> !busy)
        else $error("final result shown while still busy");

    // a result that is not the final one comes out of an unfinished request
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |-> busy)
        else $error("non-final result with sequencer idle");

    // a taken request always occupies the sequencer
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but sequencer not busy");

    // the high bound of the ack check only follows the low bound check
    a_ack_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACK_HI) |-> ($past(state_reg) == S_ACK_LO))
        else $error("ack high bound check out of order");

endmodule
